// ===== rtl/fir_q15_filter_assert.svh =====
// assertion macros shared by the fir_q15 rtl
// the using module provides clock and reset signals under those names
`ifndef FIR_Q15_FILTER_ASSERT_SVH
`define FIR_Q15_FILTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fir_q15 assertion failed");

// consequent checked in the cycle after the antecedent
`define FQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fir_q15 assertion failed");

`endif

// ===== rtl/fir_q15_pkg.sv =====
package fir_q15_pkg;

   localparam int TAPS       = 63;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int ACC_W      = PROD_W + 1 + $clog2(TAPS);
   localparam int COEF_DEPTH = 63;
   localparam int COEF_IDX_W = $clog2(COEF_DEPTH);
   localparam int OUT_SHIFT  = 15;

   localparam logic signed [ACC_W-1:0] ROUND_CONST = ACC_W'(1) <<< 14;
   localparam logic signed [ACC_W-1:0] SUM_MAX     = ACC_W'(32'sh3fff_ffff);
   localparam logic signed [ACC_W-1:0] SUM_MIN     = ACC_W'(-32'sh4000_0000);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   // symmetric low-pass table
   localparam sample_type COEF_TABLE [COEF_DEPTH] = '{
      -16'sd35, -16'sd37, -16'sd41, -16'sd45, -16'sd50, -16'sd55, -16'sd58,
      -16'sd57, -16'sd52, -16'sd39, -16'sd18, 16'sd14, 16'sd58, 16'sd116,
      16'sd189, 16'sd276, 16'sd379, 16'sd495, 16'sd625, 16'sd766, 16'sd915,
      16'sd1069, 16'sd1225, 16'sd1379, 16'sd1528, 16'sd1666, 16'sd1791,
      16'sd1899, 16'sd1986, 16'sd2051, 16'sd2090, 16'sd2103, 16'sd2090,
      16'sd2051, 16'sd1986, 16'sd1899, 16'sd1791, 16'sd1666, 16'sd1528,
      16'sd1379, 16'sd1225, 16'sd1069, 16'sd915, 16'sd766, 16'sd625,
      16'sd495, 16'sd379, 16'sd276, 16'sd189, 16'sd116, 16'sd58, 16'sd14,
      -16'sd18, -16'sd39, -16'sd52, -16'sd57, -16'sd58, -16'sd55, -16'sd50,
      -16'sd45, -16'sd41, -16'sd37, -16'sd35
   };

   // taps past the end of the table weigh zero
   function automatic sample_type coef_at(input int k);
      sample_type c;
      c = '0;
      if (k < COEF_DEPTH) begin
         c = COEF_TABLE[COEF_IDX_W'(k)];
      end
      return c;
   endfunction

endpackage

// ===== rtl/fir_q15_cell.sv =====
// one tap of the transposed chain: partial sum = coef * sample + upstream sum
module fir_q15_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  fir_q15_pkg::sample_type sample,
   input  fir_q15_pkg::sample_type coef,
   input  fir_q15_pkg::acc_type    psum_in,
   output fir_q15_pkg::acc_type    psum_out
);

   logic signed [fir_q15_pkg::PROD_W-1:0] prod;
   fir_q15_pkg::acc_type                  psum_ff;
   fir_q15_pkg::acc_type                  psum_in_next;

   assign prod         = coef * sample;
   assign psum_in_next = fir_q15_pkg::ACC_W'(prod) + psum_in;
   assign psum_out     = psum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         psum_ff <= '0;
      end else if (shift_en) begin
         psum_ff <= psum_in_next;
      end
   end

endmodule

// ===== rtl/fir_q15_filter.sv =====
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_sample_in (s16 q15)
// rsp       out        rsp_valid/rsp_stall  rsp_filtered_sample (s16 q15)
//
// one sample per cycle sustained while rsp_stall is low, result valid in the cycle after the input transfer
// the filter is a transposed chain of TAPS-1 cells, one multiplier each,
// plus the tap-zero multiplier in the output stage
// synchronous reset zeroes every partial sum, i.e. an all-zero history
// req_stall rises only while a result sits in the output register and
// rsp_stall holds it; the chain advances on input transfers only
module fir_q15_filter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fir_q15_pkg::sample_type req_sample_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output fir_q15_pkg::sample_type rsp_filtered_sample
);

   localparam int N = fir_q15_pkg::TAPS;

   // input transfer advances every cell at once
   logic req_xfer;

   // psum[k] is the partial sum leaving cell k; the top of the chain is zero
   fir_q15_pkg::acc_type psum [1:N];

   // tap zero, rounding and clamping
   logic signed [fir_q15_pkg::PROD_W-1:0] prod0;
   fir_q15_pkg::acc_type                  acc_full;
   fir_q15_pkg::acc_type                  acc_sat;
   fir_q15_pkg::sample_type               result;

   // output register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   fir_q15_pkg::sample_type rsp_data_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   assign psum[N] = '0;

   for (genvar g = 1; g < N; g++) begin : g_cell
      fir_q15_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_xfer),
         .sample   (req_sample_in),
         .coef     (fir_q15_pkg::coef_at(g)),
         .psum_in  (psum[g+1]),
         .psum_out (psum[g])
      );
   end

   // newest sample meets coefficient zero here
   assign prod0    = fir_q15_pkg::coef_at(0) * req_sample_in;
   assign acc_full = fir_q15_pkg::ACC_W'(prod0) + psum[1] + fir_q15_pkg::ROUND_CONST;

   always_comb begin
      if (acc_full > fir_q15_pkg::SUM_MAX) begin
         acc_sat = fir_q15_pkg::SUM_MAX;
      end else if (acc_full < fir_q15_pkg::SUM_MIN) begin
         acc_sat = fir_q15_pkg::SUM_MIN;
      end else begin
         acc_sat = acc_full;
      end
   end

   // q30 to q15, rounded by ROUND_CONST before the clamp: the clamped value fits in 31 bits
   assign result = acc_sat[fir_q15_pkg::OUT_SHIFT + fir_q15_pkg::SAMPLE_W - 1
                           : fir_q15_pkg::OUT_SHIFT];

   // output register fills on input transfer, empties on output transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_data_ff;

`include "fir_q15_filter_assert.svh"

   // input is held off only by a stalled, full output register
   `FQ_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   // every input transfer leaves a result waiting
   `FQ_ASSERT_NEXT(a_xfer_result, req_valid && !req_stall, rsp_valid)
   // a taken result with no new input leaves the register empty
   `FQ_ASSERT_NEXT(a_drain_empty, rsp_valid && !rsp_stall && !(req_valid && !req_stall),
                   !rsp_valid)

endmodule

// ===== bench/fir_q15_checker.sv =====
module fir_q15_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  fir_q15_pkg::sample_type req_sample_in,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  fir_q15_pkg::sample_type rsp_filtered_sample,
   output int                      mismatch_count,
   output int                      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import fir_q15_pkg::*;

   localparam int REPORT_LIMIT = 10;

   sample_type history [TAPS-1];
   sample_type coef_mem [TAPS];
   sample_type expected_outputs [$];
   int         fail_total = 0;

   // one filter step: q30 dot product plus ROUND_CONST, clamp, floor shift back to q15
   function automatic sample_type filter_sample(input sample_type x);
      longint acc;
      acc = longint'(ROUND_CONST) + longint'(coef_mem[0]) * longint'(x);
      for (int k = 1; k < TAPS; k++) begin
         acc += longint'(coef_mem[k]) * longint'(history[k-1]);
      end
      if (acc > longint'(SUM_MAX)) begin
         acc = longint'(SUM_MAX);
      end else if (acc < longint'(SUM_MIN)) begin
         acc = longint'(SUM_MIN);
      end
      for (int k = TAPS - 2; k > 0; k--) begin
         history[k] = history[k-1];
      end
      history[0] = x;
      return sample_type'(acc >>> OUT_SHIFT);
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         for (int k = 0; k < TAPS - 1; k++) begin
            history[k] = '0;
         end
         for (int k = 0; k < TAPS; k++) begin
            coef_mem[k] = (k < COEF_DEPTH) ? COEF_TABLE[k] : '0;
         end
         expected_outputs.delete();
      end else begin
         // result side first, a result never belongs to the input of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT) begin
                  $display("unexpected filtered sample %0d with nothing pending",
                     rsp_filtered_sample);
               end
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_filtered_sample !== want) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $display("filtered sample mismatch: expected %0d, got %0d",
                        want, rsp_filtered_sample);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_outputs.push_back(filter_sample(req_sample_in));
         end
      end
      outstanding    <= expected_outputs.size();
      mismatch_count <= fail_total;
   end

endmodule

// ===== bench/tb_fir_q15_filter.sv =====
module tb_fir_q15_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import fir_q15_pkg::*;

   // rough number of random samples, spread over the phases
   localparam int ITEM_TARGET = 900;
   localparam int PHASES      = 4;
   localparam int DRAIN_WAIT  = 8;
   localparam int CORNERS     = 17;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   sample_type req_sample_in = '0;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   sample_type rsp_filtered_sample;
   int         mismatch_count;
   int         outstanding;

   // idle and stall odds in percent, changed per phase
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // hand-picked samples: rails, zero, +/-1, impulses and bit patterns
   sample_type corner_samples [CORNERS] = '{
      16'sh7fff, 16'sh0000, 16'sh0000, -16'sh8000, 16'sh0000, -16'sh0001,
      16'sh0001, -16'sh0001, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
      16'sh5555, -16'sh5556, 16'sh0000, 16'sh0100, -16'sh0100
   };

   fir_q15_filter u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_in       (req_sample_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample)
   );

   // watches both channels, predicts each output sample and compares
   fir_q15_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_in       (req_sample_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver side: random stall at the current phase's odds
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // one sample transfer, with random idle cycles ahead of it
   // stall is looked at on the falling edge, where every input has settled
   task automatic send_sample(input sample_type value);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
   endtask

   // pick from the rails and the values next to zero
   function automatic sample_type pick_extreme();
      sample_type v;
      case ($urandom_range(4))
         0:       v = 16'sh7fff;
         1:       v = -16'sh8000;
         2:       v = 16'sh0000;
         3:       v = -16'sh0001;
         default: v = 16'sh0001;
      endcase
      return v;
   endfunction

   // one run of related samples; count tells how many went out
   task automatic send_burst(output int count);
      int         mode;
      int         len;
      int         flip;
      int         mag;
      logic       neg;
      sample_type v;
      mode = $urandom_range(99);
      if (mode < 25) begin
         // full window with signs following the coefficient signs, so the
         // sum runs past the q30 rails; flip picks the rail
         flip = $urandom_range(1);
         for (int i = 0; i < COEF_DEPTH; i++) begin
            mag = $urandom_range(32767, 32000);
            neg = (COEF_TABLE[i] < 0) ^ flip[0];
            v   = neg ? sample_type'(-mag - 1) : sample_type'(mag);
            send_sample(v);
         end
         count = COEF_DEPTH;
      end else if (mode < 55) begin
         // full-range noise
         len = $urandom_range(40, 1);
         for (int i = 0; i < len; i++) begin
            send_sample(sample_type'($urandom));
         end
         count = len;
      end else if (mode < 80) begin
         // steady levels or a jumble of extremes
         len = $urandom_range(30, 1);
         v   = pick_extreme();
         flip = $urandom_range(1);
         for (int i = 0; i < len; i++) begin
            if (flip != 0) begin
               v = pick_extreme();
            end
            send_sample(v);
         end
         count = len;
      end else begin
         // low-level signal around zero
         len = $urandom_range(40, 1);
         for (int i = 0; i < len; i++) begin
            send_sample(sample_type'($urandom_range(400) - 200));
         end
         count = len;
      end
   endtask

   // drop valid and hold off until every output sample is back
   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int sent;
      int burst;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed corners with no idling
      foreach (corner_samples[i]) begin
         send_sample(corner_samples[i]);
      end
      drain_outputs();

      // phases: free running, sender idle, receiver stalling, both lightly
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct   = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct   = 87;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct   = 0;
               recv_stall_pct <= 87;
            end
            default: begin
               send_idle_pct   = 21;
               recv_stall_pct <= 21;
            end
         endcase
         sent = 0;
         while (sent < ITEM_TARGET / PHASES) begin
            send_burst(burst);
            sent += burst;
         end
         // sender holds off until the pipe is empty before the next phase
         drain_outputs();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hang guard, far past the slowest legal run
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
